### rtl/plp_pkg.sv
// ----------------------------------------------------------------------------
// plp_pkg
// Shared widths, register codes and fixed-point helpers for the particle push.
// ----------------------------------------------------------------------------
package plp_pkg;

	localparam int DATA_W  = 32;
	localparam int FRAC_W  = 16;
	localparam int MASS_W  = 31;
	localparam int DT_W    = 31;
	localparam int PROD_W  = DATA_W + DT_W;
	localparam int INC_W   = 41;
	localparam int QB      = INC_W;
	localparam int REM_W   = MASS_W + 2;
	localparam int SUM_W   = INC_W + 3;
	localparam int LANE_LAT = QB + 5;
	localparam int ADDR_W  = 3;

	localparam logic [DT_W-1:0] DT_RESET = DT_W'(65536);

	typedef logic signed [DATA_W-1:0] word_t;
	typedef logic [DATA_W-1:0]        mag_t;
	typedef logic [PROD_W-1:0]        prod_t;
	typedef logic [INC_W-1:0]         inc_t;

	typedef enum logic {
		REG_TIME_STEP   = 1'b0,
		REG_SCHEME_MODE = 1'b1
	} reg_idx_t;

	typedef enum logic {
		MODE_KDK = 1'b0,
		MODE_DKD = 1'b1
	} mode_t;

	localparam inc_t INC_CAP = inc_t'(1) << (INC_W - 1);

	function automatic mag_t mag(input word_t a);
		mag = a[DATA_W-1] ? mag_t'(-a) : mag_t'(a);
	endfunction

	function automatic inc_t cap(input prod_t p);
		cap = (p > prod_t'(INC_CAP)) ? INC_CAP : p[INC_W-1:0];
	endfunction

	function automatic word_t sat_add(input word_t b, input inc_t i, input logic neg);
		logic signed [SUM_W-1:0] s;
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		s  = neg ? (SUM_W'(b) - $signed({3'b000, i})) : (SUM_W'(b) + $signed({3'b000, i}));
		hi = SUM_W'($signed({1'b0, {(DATA_W-1){1'b1}}}));
		lo = SUM_W'($signed({1'b1, {(DATA_W-1){1'b0}}}));
		if (s > hi) begin
			sat_add = hi[DATA_W-1:0];
		end else if (s < lo) begin
			sat_add = lo[DATA_W-1:0];
		end else begin
			sat_add = s[DATA_W-1:0];
		end
	endfunction

endpackage

### rtl/plp_if.sv
// ----------------------------------------------------------------------------
// plp_if
// Valid/ready channels for particle items and pushed results.
// ----------------------------------------------------------------------------
interface plp_in_if;
	logic               valid;
	logic               ready;
	plp_pkg::word_t     pos_x;
	plp_pkg::word_t     pos_y;
	plp_pkg::word_t     pos_z;
	plp_pkg::word_t     vel_x;
	plp_pkg::word_t     vel_y;
	plp_pkg::word_t     vel_z;
	plp_pkg::word_t     force_x;
	plp_pkg::word_t     force_y;
	plp_pkg::word_t     force_z;
	logic [30:0]        mass;
	logic               last_in;

	modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
		force_x, force_y, force_z, mass, last_in, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
		force_x, force_y, force_z, mass, last_in, output ready);
endinterface

interface plp_out_if;
	logic               valid;
	logic               ready;
	plp_pkg::word_t     new_pos_x;
	plp_pkg::word_t     new_pos_y;
	plp_pkg::word_t     new_pos_z;
	plp_pkg::word_t     new_vel_x;
	plp_pkg::word_t     new_vel_y;
	plp_pkg::word_t     new_vel_z;
	logic               last_out;

	modport source (output valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x,
		new_vel_y, new_vel_z, last_out, input ready);
	modport sink (input valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x,
		new_vel_y, new_vel_z, last_out, output ready);
endinterface

### rtl/particle_leapfrog_push.sv
// ----------------------------------------------------------------------------
// particle_leapfrog_push
// One-step leapfrog push of a particle, three axis lanes in parallel.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one particle per item (position, velocity, force, mass,
//          last flag); out_ch returns its advanced position and velocity.
//   The APB port holds time_step (0x0) and scheme_mode (0x4); write them
//   only while no item is in flight.
//   Throughput: one item per cycle while out_ch is not stalled. Each lane runs
//   through the 41-stage restoring divider that forms the kick increment,
//   plus multiply, kick and drift stages, then the output register.
//   When out_ch stalls with a result held, the whole pipeline freezes and
//   in_ch.ready drops; nothing is lost.
//   Reset clears all valid bits and loads time_step = 1.0, scheme_mode = 0.
// ----------------------------------------------------------------------------
module particle_leapfrog_push (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [plp_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	plp_in_if.sink                      in_ch,
	plp_out_if.source                   out_ch
);
	import plp_pkg::*;

	logic [DT_W-1:0]      dt_q;
	logic                 mode_q;
	logic                 en;
	logic [LANE_LAT-1:0]  vld_q;
	logic [LANE_LAT-1:0]  last_q;
	word_t                px, py, pz, vx, vy, vz;
	reg_idx_t             idx;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q   <= DT_RESET;
			mode_q <= MODE_KDK;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_TIME_STEP:   dt_q   <= pwdata[DT_W-1:0];
				REG_SCHEME_MODE: mode_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_TIME_STEP:   prdata = {1'b0, dt_q};
			REG_SCHEME_MODE: prdata = {31'b0, mode_q};
			default:         prdata = '0;
		endcase
	end

	assign in_ch.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LANE_LAT-2:0], in_ch.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_q <= {last_q[LANE_LAT-2:0], in_ch.last_in};
		end
	end

	plp_lane u_lane_x (
		.clk (clk), .en (en), .mode (mode_q), .dt (dt_q), .mass (in_ch.mass),
		.pos (in_ch.pos_x), .vel (in_ch.vel_x), .frc (in_ch.force_x),
		.new_pos (px), .new_vel (vx)
	);

	plp_lane u_lane_y (
		.clk (clk), .en (en), .mode (mode_q), .dt (dt_q), .mass (in_ch.mass),
		.pos (in_ch.pos_y), .vel (in_ch.vel_y), .frc (in_ch.force_y),
		.new_pos (py), .new_vel (vy)
	);

	plp_lane u_lane_z (
		.clk (clk), .en (en), .mode (mode_q), .dt (dt_q), .mass (in_ch.mass),
		.pos (in_ch.pos_z), .vel (in_ch.vel_z), .frc (in_ch.force_z),
		.new_pos (pz), .new_vel (vz)
	);

	plp_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.lane_vld  (vld_q[LANE_LAT-1]),
		.lane_last (last_q[LANE_LAT-1]),
		.px (px), .py (py), .pz (pz),
		.vx (vx), .vy (vy), .vz (vz),
		.en        (en),
		.out_ch    (out_ch)
	);

endmodule

### rtl/plp_lane.sv
// ----------------------------------------------------------------------------
// plp_lane
// One axis of the push: kick divider pipeline, drift multiply, saturation.
// ----------------------------------------------------------------------------
module plp_lane (
	input  logic                            clk,
	input  logic                            en,
	input  logic                            mode,
	input  logic [plp_pkg::DT_W-1:0]        dt,
	input  logic [plp_pkg::MASS_W-1:0]      mass,
	input  plp_pkg::word_t                  pos,
	input  plp_pkg::word_t                  vel,
	input  plp_pkg::word_t                  frc,
	output plp_pkg::word_t                  new_pos,
	output plp_pkg::word_t                  new_vel
);
	import plp_pkg::*;

	// stage 1: products
	prod_t              num_s1, pd_s1;
	word_t              x_s1, v_s1;
	logic               fneg_s1, mz_s1;
	logic [MASS_W:0]    den_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1  <= prod_t'(mag(frc)) * prod_t'(dt);
			pd_s1   <= prod_t'(mag(vel)) * prod_t'(dt);
			x_s1    <= pos;
			v_s1    <= vel;
			fneg_s1 <= frc[DATA_W-1];
			mz_s1   <= (mass == '0);
			den_s1  <= (mode == MODE_DKD) ? {1'b0, mass} : {mass, 1'b0};
		end
	end

	// stage 2: overflow check, divider seed, first half drift in DKD mode
	logic [REM_W-1:0]   rem_d [QB+1];
	logic [QB-1:0]      nb_d  [QB+1];
	logic [QB-1:0]      q_d   [QB+1];
	logic [MASS_W:0]    den_d [QB+1];
	word_t              x_d   [QB+1];
	word_t              v_d   [QB+1];
	logic               fn_d  [QB+1];
	logic               mz_d  [QB+1];
	logic               ov_d  [QB+1];

	always_ff @(posedge clk) begin
		if (en) begin
			ov_d[0]  <= ({(MASS_W+1+QB-PROD_W)'(0), num_s1} >= {den_s1, {QB{1'b0}}});
			rem_d[0] <= REM_W'(num_s1[PROD_W-1:QB]);
			nb_d[0]  <= num_s1[QB-1:0];
			q_d[0]   <= '0;
			den_d[0] <= den_s1;
			x_d[0]   <= (mode == MODE_DKD) ?
				sat_add(x_s1, cap(pd_s1 >> (FRAC_W + 1)), v_s1[DATA_W-1]) : x_s1;
			v_d[0]   <= v_s1;
			fn_d[0]  <= fneg_s1;
			mz_d[0]  <= mz_s1;
		end
	end

	// restoring divider, one quotient bit per stage
	for (genvar i = 0; i < QB; i++) begin : g_div
		logic [REM_W-1:0] t;
		logic             ge;
		assign t  = {rem_d[i][REM_W-2:0], nb_d[i][QB-1]};
		assign ge = (t >= REM_W'(den_d[i]));

		always_ff @(posedge clk) begin
			if (en) begin
				rem_d[i+1] <= ge ? (t - REM_W'(den_d[i])) : t;
				nb_d[i+1]  <= {nb_d[i][QB-2:0], 1'b0};
				q_d[i+1]   <= {q_d[i][QB-2:0], ge};
				den_d[i+1] <= den_d[i];
				x_d[i+1]   <= x_d[i];
				v_d[i+1]   <= v_d[i];
				fn_d[i+1]  <= fn_d[i];
				mz_d[i+1]  <= mz_d[i];
				ov_d[i+1]  <= ov_d[i];
			end
		end
	end

	// kick increment, velocity update (first half kick in KDK, full kick in DKD)
	inc_t  qc;
	word_t x_sa, v_sa;
	inc_t  qc_sa;
	logic  fn_sa, mz_sa;

	assign qc = ov_d[QB] ? INC_CAP : cap(prod_t'(q_d[QB]));

	always_ff @(posedge clk) begin
		if (en) begin
			v_sa  <= mz_d[QB] ? v_d[QB] : sat_add(v_d[QB], qc, fn_d[QB]);
			x_sa  <= x_d[QB];
			qc_sa <= qc;
			fn_sa <= fn_d[QB];
			mz_sa <= mz_d[QB];
		end
	end

	// drift product on updated velocity
	prod_t pd_sb;
	word_t x_sb, v_sb;
	inc_t  qc_sb;
	logic  fn_sb, mz_sb;

	always_ff @(posedge clk) begin
		if (en) begin
			pd_sb <= prod_t'(mag(v_sa)) * prod_t'(dt);
			x_sb  <= x_sa;
			v_sb  <= v_sa;
			qc_sb <= qc_sa;
			fn_sb <= fn_sa;
			mz_sb <= mz_sa;
		end
	end

	// final drift and, in KDK mode, second kick
	always_ff @(posedge clk) begin
		if (en) begin
			new_pos <= sat_add(x_sb, (mode == MODE_DKD) ? cap(pd_sb >> (FRAC_W + 1)) :
				cap(pd_sb >> FRAC_W), v_sb[DATA_W-1]);
			new_vel <= (mode == MODE_KDK && !mz_sb) ? sat_add(v_sb, qc_sb, fn_sb) : v_sb;
		end
	end

endmodule

### rtl/plp_merge.sv
// ----------------------------------------------------------------------------
// plp_merge
// Gathers the three lane results into the output register and runs flow control.
// ----------------------------------------------------------------------------
module plp_merge (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            lane_vld,
	input  logic            lane_last,
	input  plp_pkg::word_t  px,
	input  plp_pkg::word_t  py,
	input  plp_pkg::word_t  pz,
	input  plp_pkg::word_t  vx,
	input  plp_pkg::word_t  vy,
	input  plp_pkg::word_t  vz,
	output logic            en,
	plp_out_if.source       out_ch
);
	import plp_pkg::*;

	logic out_vld_q;

	assign en           = !out_vld_q || out_ch.ready;
	assign out_ch.valid = out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= lane_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_ch.new_pos_x <= px;
			out_ch.new_pos_y <= py;
			out_ch.new_pos_z <= pz;
			out_ch.new_vel_x <= vx;
			out_ch.new_vel_y <= vy;
			out_ch.new_vel_z <= vz;
			out_ch.last_out  <= lane_last;
		end
	end

endmodule
